>>> rtl/stt_pkg.sv
package stt_pkg;

  localparam int unsigned POS_W = 16;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW = $clog2(Q_DEPTH);

  // one-hot scan modes
  typedef enum logic [8:0] {
    MODE_IDLE     = 9'b000000001,
    MODE_IDENT    = 9'b000000010,
    MODE_INT      = 9'b000000100,
    MODE_STR      = 9'b000001000,
    MODE_ESC      = 9'b000010000,
    MODE_PEND     = 9'b000100000,
    MODE_LINE_CMT = 9'b001000000,
    MODE_BLK_CMT  = 9'b010000000,
    MODE_BLK_STAR = 9'b100000000
  } mode_e;

  localparam logic [4:0] KIND_NONE    = 5'd0;
  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_IDENT   = 5'd1;
  localparam logic [4:0] KIND_INT     = 5'd2;
  localparam logic [4:0] KIND_STR     = 5'd3;
  localparam logic [4:0] KIND_UNKNOWN = 5'd4;
  localparam logic [4:0] KIND_ASSIGN  = 5'd5;
  localparam logic [4:0] KIND_EQ      = 5'd6;
  localparam logic [4:0] KIND_PLUS    = 5'd7;
  localparam logic [4:0] KIND_MINUS   = 5'd8;
  localparam logic [4:0] KIND_ARROW   = 5'd9;
  localparam logic [4:0] KIND_STAR    = 5'd10;
  localparam logic [4:0] KIND_DIV     = 5'd11;
  localparam logic [4:0] KIND_MOD     = 5'd12;
  localparam logic [4:0] KIND_NOT     = 5'd13;
  localparam logic [4:0] KIND_NE      = 5'd14;
  localparam logic [4:0] KIND_LT      = 5'd15;
  localparam logic [4:0] KIND_LE      = 5'd16;
  localparam logic [4:0] KIND_GT      = 5'd17;
  localparam logic [4:0] KIND_GE      = 5'd18;
  localparam logic [4:0] KIND_LAND    = 5'd19;
  localparam logic [4:0] KIND_LOR     = 5'd20;
  localparam logic [4:0] KIND_LPAREN  = 5'd21;
  localparam logic [4:0] KIND_RPAREN  = 5'd22;
  localparam logic [4:0] KIND_LBRACE  = 5'd23;
  localparam logic [4:0] KIND_RBRACE  = 5'd24;
  localparam logic [4:0] KIND_LBRACK  = 5'd25;
  localparam logic [4:0] KIND_RBRACK  = 5'd26;
  localparam logic [4:0] KIND_COMMA   = 5'd27;
  localparam logic [4:0] KIND_COLON   = 5'd28;
  localparam logic [4:0] KIND_SEMI    = 5'd29;
  localparam logic [4:0] KIND_DOT     = 5'd30;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [4:0]       kind;
    logic [7:0]       value;
    logic             has;
    logic             first;
    logic             last;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
  } rec_t;

  // one or two results caused by one character
  typedef struct packed {
    logic two;
    rec_t r0;
    rec_t r1;
  } entry_t;

  function automatic rec_t mk_rec(logic [4:0] kind, logic [7:0] value, logic has,
                                  logic first, logic last,
                                  logic [POS_W-1:0] line, logic [POS_W-1:0] column);
    rec_t r;
    r.kind   = kind;
    r.value  = has ? value : 8'h00;
    r.has    = has;
    r.first  = first;
    r.last   = last;
    r.line   = line;
    r.column = column;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_USCORE;
  endfunction

  // characters that may open a two-character operator or a comment
  function automatic logic is_pend(logic [7:0] c);
    return c == "=" || c == "-" || c == "!" || c == "<" || c == ">" ||
           c == "&" || c == "|" || c == "/";
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      "+":     k = KIND_PLUS;
      "*":     k = KIND_STAR;
      "%":     k = KIND_MOD;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "[":     k = KIND_LBRACK;
      "]":     k = KIND_RBRACK;
      ",":     k = KIND_COMMA;
      ":":     k = KIND_COLON;
      ";":     k = KIND_SEMI;
      ".":     k = KIND_DOT;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] alone_kind(logic [7:0] p);
    logic [4:0] k;
    unique case (p)
      "=":     k = KIND_ASSIGN;
      "-":     k = KIND_MINUS;
      "!":     k = KIND_NOT;
      "<":     k = KIND_LT;
      ">":     k = KIND_GT;
      "/":     k = KIND_DIV;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] pair_kind(logic [7:0] p, logic [7:0] c);
    logic [4:0] k;
    k = KIND_NONE;
    if (p == "=" && c == "=") k = KIND_EQ;
    if (p == "-" && c == ">") k = KIND_ARROW;
    if (p == "!" && c == "=") k = KIND_NE;
    if (p == "<" && c == "=") k = KIND_LE;
    if (p == ">" && c == "=") k = KIND_GE;
    if (p == "&" && c == "&") k = KIND_LAND;
    if (p == "|" && c == "|") k = KIND_LOR;
    return k;
  endfunction

endpackage

>>> rtl/stt_front.sv
module stt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          character_i,
  input  logic                q_full_i,
  output logic                push_o,
  output stt_pkg::entry_t     push_data_o
);

  stt_pkg::mode_e               mode_q, mode_d, st_mode;
  logic [7:0]                   pend_q, pend_d;
  logic [stt_pkg::POS_W-1:0]    line_q, line_d, col_q, col_d;
  logic [stt_pkg::POS_W-1:0]    tline_q, tline_d, tcol_q, tcol_d;
  logic [stt_pkg::POS_W-1:0]    line_n, col_n;
  logic                         started_q, started_d;
  logic                         accept;
  logic [7:0]                   c, esc_byte;
  logic [4:0]                   pk;

  logic                         st_emit, st_pend_set, st_mark, st_reset, st_clr;
  stt_pkg::rec_t                st_res, r0, r1;
  logic                         n0, n1, do_start;

  assign c          = character_i;
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // position update, saturating
  always_comb begin
    line_n = line_q;
    col_n  = col_q;
    if (c == stt_pkg::CH_LF) begin
      if (line_q != '1) line_n = line_q + 1'b1;
      col_n = '0;
    end else if (col_q != '1) begin
      col_n = col_q + 1'b1;
    end
  end

  // handling of a character seen between tokens
  always_comb begin
    st_emit     = 1'b0;
    st_res      = '0;
    st_mode     = stt_pkg::MODE_IDLE;
    st_pend_set = 1'b0;
    st_mark     = 1'b0;
    st_reset    = 1'b0;
    st_clr      = 1'b0;
    if (c == stt_pkg::CH_NUL) begin
      st_emit  = 1'b1;
      st_res   = stt_pkg::mk_rec(stt_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, line_n, col_n);
      st_reset = 1'b1;
    end else if (!stt_pkg::is_space(c)) begin
      st_mark = 1'b1;
      if (stt_pkg::is_pend(c)) begin
        st_pend_set = 1'b1;
        st_mode     = stt_pkg::MODE_PEND;
      end else if (c == stt_pkg::CH_QUOTE) begin
        st_clr  = 1'b1;
        st_mode = stt_pkg::MODE_STR;
      end else if (stt_pkg::is_alpha(c) || c == stt_pkg::CH_USCORE) begin
        st_emit = 1'b1;
        st_res  = stt_pkg::mk_rec(stt_pkg::KIND_IDENT, c, 1'b1, 1'b1, 1'b0, line_n, col_n);
        st_mode = stt_pkg::MODE_IDENT;
      end else if (stt_pkg::is_digit(c)) begin
        st_emit = 1'b1;
        st_res  = stt_pkg::mk_rec(stt_pkg::KIND_INT, c, 1'b1, 1'b1, 1'b0, line_n, col_n);
        st_mode = stt_pkg::MODE_INT;
      end else begin
        st_emit = 1'b1;
        st_res  = stt_pkg::mk_rec(stt_pkg::single_kind(c), c, 1'b1, 1'b1, 1'b1,
                                  line_n, col_n);
      end
    end
  end

  assign esc_byte = (c == "n") ? stt_pkg::CH_LF : (c == "t") ? stt_pkg::CH_TAB : c;
  assign pk       = stt_pkg::pair_kind(pend_q, c);

  always_comb begin
    mode_d    = mode_q;
    pend_d    = pend_q;
    line_d    = line_n;
    col_d     = col_n;
    tline_d   = tline_q;
    tcol_d    = tcol_q;
    started_d = started_q;
    r0        = '0;
    r1        = '0;
    n0        = 1'b0;
    n1        = 1'b0;
    do_start  = 1'b0;
    unique case (mode_q) inside
      stt_pkg::MODE_IDENT, stt_pkg::MODE_INT: begin
        if ((mode_q == stt_pkg::MODE_IDENT && stt_pkg::is_word(c)) ||
            (mode_q == stt_pkg::MODE_INT && stt_pkg::is_digit(c))) begin
          r0 = stt_pkg::mk_rec((mode_q == stt_pkg::MODE_IDENT) ? stt_pkg::KIND_IDENT
                               : stt_pkg::KIND_INT, c, 1'b1, 1'b0, 1'b0, tline_q, tcol_q);
          n0 = 1'b1;
        end else begin
          r0 = stt_pkg::mk_rec((mode_q == stt_pkg::MODE_IDENT) ? stt_pkg::KIND_IDENT
                               : stt_pkg::KIND_INT, 8'h00, 1'b0, 1'b0, 1'b1,
                               tline_q, tcol_q);
          n0 = 1'b1;
          do_start = 1'b1;
        end
      end
      stt_pkg::MODE_STR: begin
        if (c == stt_pkg::CH_QUOTE || c == stt_pkg::CH_NUL) begin
          r0 = stt_pkg::mk_rec(stt_pkg::KIND_STR, 8'h00, 1'b0, !started_q, 1'b1,
                               tline_q, tcol_q);
          n0        = 1'b1;
          started_d = 1'b0;
          mode_d    = stt_pkg::MODE_IDLE;
          do_start  = (c == stt_pkg::CH_NUL);
        end else if (c == stt_pkg::CH_BSLASH) begin
          mode_d = stt_pkg::MODE_ESC;
        end else begin
          r0 = stt_pkg::mk_rec(stt_pkg::KIND_STR, c, 1'b1, !started_q, 1'b0,
                               tline_q, tcol_q);
          n0        = 1'b1;
          started_d = 1'b1;
        end
      end
      stt_pkg::MODE_ESC: begin
        if (c == stt_pkg::CH_NUL) begin
          r0 = stt_pkg::mk_rec(stt_pkg::KIND_STR, 8'h00, 1'b0, !started_q, 1'b1,
                               tline_q, tcol_q);
          n0        = 1'b1;
          started_d = 1'b0;
          do_start  = 1'b1;
        end else begin
          r0 = stt_pkg::mk_rec(stt_pkg::KIND_STR, esc_byte, 1'b1, !started_q, 1'b0,
                               tline_q, tcol_q);
          n0        = 1'b1;
          started_d = 1'b1;
          mode_d    = stt_pkg::MODE_STR;
        end
      end
      stt_pkg::MODE_PEND: begin
        pend_d = 8'h00;
        if (pend_q == "/" && c == "/") begin
          mode_d = stt_pkg::MODE_LINE_CMT;
        end else if (pend_q == "/" && c == "*") begin
          mode_d = stt_pkg::MODE_BLK_CMT;
        end else if (pk != stt_pkg::KIND_NONE) begin
          r0 = stt_pkg::mk_rec(pk, pend_q, 1'b1, 1'b1, 1'b0, tline_q, tcol_q);
          r1 = stt_pkg::mk_rec(pk, c, 1'b1, 1'b0, 1'b1, tline_q, tcol_q);
          n0     = 1'b1;
          n1     = 1'b1;
          mode_d = stt_pkg::MODE_IDLE;
        end else begin
          r0 = stt_pkg::mk_rec(stt_pkg::alone_kind(pend_q), pend_q, 1'b1, 1'b1, 1'b1,
                               tline_q, tcol_q);
          n0       = 1'b1;
          do_start = 1'b1;
        end
      end
      stt_pkg::MODE_LINE_CMT: begin
        if (c == stt_pkg::CH_LF) mode_d = stt_pkg::MODE_IDLE;
        else if (c == stt_pkg::CH_NUL) do_start = 1'b1;
      end
      stt_pkg::MODE_BLK_CMT: begin
        if (c == "*") mode_d = stt_pkg::MODE_BLK_STAR;
        else if (c == stt_pkg::CH_NUL) do_start = 1'b1;
      end
      stt_pkg::MODE_BLK_STAR: begin
        if (c == "/") mode_d = stt_pkg::MODE_IDLE;
        else if (c == stt_pkg::CH_NUL) do_start = 1'b1;
        else if (c != "*") mode_d = stt_pkg::MODE_BLK_CMT;
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    if (do_start) begin
      mode_d = st_mode;
      if (st_pend_set) pend_d = c;
      if (st_mark) begin
        tline_d = line_n;
        tcol_d  = col_n;
      end
      if (st_clr) started_d = 1'b0;
      if (st_emit) begin
        if (n0) begin
          r1 = st_res;
          n1 = 1'b1;
        end else begin
          r0 = st_res;
          n0 = 1'b1;
        end
      end
      // end of text returns everything to the reset state
      if (st_reset) begin
        mode_d    = stt_pkg::MODE_IDLE;
        pend_d    = 8'h00;
        line_d    = {{(stt_pkg::POS_W-1){1'b0}}, 1'b1};
        col_d     = '0;
        tline_d   = {{(stt_pkg::POS_W-1){1'b0}}, 1'b1};
        tcol_d    = '0;
        started_d = 1'b0;
      end
    end
  end

  assign push_o         = accept && n0;
  assign push_data_o.two = n1;
  assign push_data_o.r0  = r0;
  assign push_data_o.r1  = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= stt_pkg::MODE_IDLE;
      pend_q    <= 8'h00;
      line_q    <= {{(stt_pkg::POS_W-1){1'b0}}, 1'b1};
      col_q     <= '0;
      tline_q   <= {{(stt_pkg::POS_W-1){1'b0}}, 1'b1};
      tcol_q    <= '0;
      started_q <= 1'b0;
    end else if (accept) begin
      mode_q    <= mode_d;
      pend_q    <= pend_d;
      line_q    <= line_d;
      col_q     <= col_d;
      tline_q   <= tline_d;
      tcol_q    <= tcol_d;
      started_q <= started_d;
    end
  end

endmodule

>>> rtl/stt_queue.sv
module stt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stt_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output stt_pkg::entry_t head_o
);

  stt_pkg::entry_t             mem_q [stt_pkg::Q_DEPTH];
  logic [stt_pkg::Q_AW-1:0]    wr_q, rd_q;
  logic [stt_pkg::Q_AW:0]      cnt_q;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == (stt_pkg::Q_AW+1)'(stt_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> rtl/stt_back.sv
module stt_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  stt_pkg::entry_t           head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output stt_pkg::rec_t             out_rec_o
);

  logic          sel_q;
  logic          valid_q;
  stt_pkg::rec_t rec_q;
  logic          load;

  // output register may refill when empty or being taken
  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && !empty_i && (sel_q || !head_i.two);

  assign out_valid_o = valid_q;
  assign out_rec_o   = rec_q;

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) rec_q <= sel_q ? head_i.r1 : head_i.r0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (!empty_i) sel_q <= !(sel_q || !head_i.two);
    end
  end

endmodule

>>> rtl/source_text_tokenizer_unit.sv
// source text tokenizer: takes one source character per cycle and streams
// tokens as one result word per token byte (identifiers, integers and strings
// add a closing word; byte 0 ends the text with an end word and resets line
// to 1 and column to 0). the scanner takes a new character every cycle while its
// four-entry queue has room; each character yields zero, one or two result
// words, and the output side sends one word per cycle while not stalled, so
// two-word characters occupy the output side for both words and set the
// sustained rate when they are frequent. a result word passes through the queue
// entry and the output register before it appears.
module source_text_tokenizer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                character_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [4:0]                token_kind_o,
  output logic [7:0]                value_byte_o,
  output logic                      has_byte_o,
  output logic                      token_first_o,
  output logic                      token_last_o,
  output logic [stt_pkg::POS_W-1:0] start_line_o,
  output logic [stt_pkg::POS_W-1:0] start_column_o
);

  logic            push, full, pop, empty;
  stt_pkg::entry_t push_data, head;
  stt_pkg::rec_t   out_rec;

  stt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .character_i (character_i),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  stt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rec_o   (out_rec)
  );

  assign token_kind_o   = out_rec.kind;
  assign value_byte_o   = out_rec.value;
  assign has_byte_o     = out_rec.has;
  assign token_first_o  = out_rec.first;
  assign token_last_o   = out_rec.last;
  assign start_line_o   = out_rec.line;
  assign start_column_o = out_rec.column;

endmodule

>>> tb/source_text_tokenizer_unit_tb.sv
`timescale 1ns / 1ps

module source_text_tokenizer_unit_tb;

  localparam int unsigned PW = stt_pkg::POS_W;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        character_i = 8'h00;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [4:0]        token_kind_o;
  logic [7:0]        value_byte_o;
  logic              has_byte_o;
  logic              token_first_o;
  logic              token_last_o;
  logic [PW-1:0]     start_line_o;
  logic [PW-1:0]     start_column_o;

  source_text_tokenizer_unit DUT (.*);

  always #10 clk_i = ~clk_i;

  typedef struct {
    string         txt;
    bit            ends;
    bit            typed;
    stt_pkg::rec_t want;
  } plan_row_t;

  localparam logic [PW-1:0] POS_SAT = '1;

  // lexer state as the testbench sees it
  stt_pkg::mode_e   lex_mode;
  logic [7:0]       held_op;
  logic [PW-1:0]    cur_line, cur_col, tok_line, tok_col;
  logic             str_open;

  stt_pkg::rec_t token_words_due[$];
  stt_pkg::rec_t due_word;
  plan_row_t     plan[$];
  int unsigned   mismatches = 0;
  int unsigned   sent = 0;
  int unsigned   rx_hold = 0;
  bit            rx_calm = 1'b0;
  bit            tx_calm = 1'b0;
  bit            paused_once = 1'b0;

  string op_spellings[28] = '{"=", "==", "+", "-", "->", "*", "/", "%", "!", "!=", "<",
                              "<=", ">", ">=", "&&", "||", "&", "|", "(", ")", "{", "}",
                              "[", "]", ",", ":", ";", "."};

  function automatic bit is_blank(logic [7:0] c);
    return c == stt_pkg::CH_SPACE || (c >= stt_pkg::CH_TAB && c <= stt_pkg::CH_CR);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_name_char(logic [7:0] c);
    return is_letter(c) || is_num(c) || c == stt_pkg::CH_USCORE;
  endfunction

  function automatic stt_pkg::rec_t token_word(logic [4:0] kind, logic [7:0] val, logic has,
                                               logic first, logic last,
                                               logic [PW-1:0] line, logic [PW-1:0] col);
    stt_pkg::rec_t w;
    w.kind   = kind;
    w.value  = has ? val : 8'h00;
    w.has    = has;
    w.first  = first;
    w.last   = last;
    w.line   = line;
    w.column = col;
    return w;
  endfunction

  task automatic emit(input logic [4:0] kind, input logic [7:0] val, input logic has,
                      input logic first, input logic last);
    token_words_due.insert(token_words_due.size(),
                           token_word(kind, val, has, first, last, tok_line, tok_col));
  endtask

  task automatic clear_lexer();
    lex_mode = stt_pkg::MODE_IDLE;
    held_op  = 8'h00;
    cur_line = PW'(1);
    cur_col  = '0;
    tok_line = PW'(1);
    tok_col  = '0;
    str_open = 1'b0;
  endtask

  // character seen between tokens
  task automatic begin_token(input logic [7:0] c);
    logic [4:0] k;
    lex_mode = stt_pkg::MODE_IDLE;
    if (c == stt_pkg::CH_NUL) begin
      tok_line = cur_line;
      tok_col  = cur_col;
      emit(stt_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
      clear_lexer();
    end else if (!is_blank(c)) begin
      tok_line = cur_line;
      tok_col  = cur_col;
      case (c) inside
        "=", "-", "!", "<", ">", "&", "|", "/": begin
          held_op  = c;
          lex_mode = stt_pkg::MODE_PEND;
        end
        stt_pkg::CH_QUOTE: begin
          str_open = 1'b0;
          lex_mode = stt_pkg::MODE_STR;
        end
        default: begin
          if (is_letter(c) || c == stt_pkg::CH_USCORE) begin
            emit(stt_pkg::KIND_IDENT, c, 1'b1, 1'b1, 1'b0);
            lex_mode = stt_pkg::MODE_IDENT;
          end else if (is_num(c)) begin
            emit(stt_pkg::KIND_INT, c, 1'b1, 1'b1, 1'b0);
            lex_mode = stt_pkg::MODE_INT;
          end else begin
            case (c)
              "+":     k = stt_pkg::KIND_PLUS;
              "*":     k = stt_pkg::KIND_STAR;
              "%":     k = stt_pkg::KIND_MOD;
              "(":     k = stt_pkg::KIND_LPAREN;
              ")":     k = stt_pkg::KIND_RPAREN;
              "{":     k = stt_pkg::KIND_LBRACE;
              "}":     k = stt_pkg::KIND_RBRACE;
              "[":     k = stt_pkg::KIND_LBRACK;
              "]":     k = stt_pkg::KIND_RBRACK;
              ",":     k = stt_pkg::KIND_COMMA;
              ":":     k = stt_pkg::KIND_COLON;
              ";":     k = stt_pkg::KIND_SEMI;
              ".":     k = stt_pkg::KIND_DOT;
              default: k = stt_pkg::KIND_UNKNOWN;
            endcase
            emit(k, c, 1'b1, 1'b1, 1'b1);
          end
        end
      endcase
    end
  endtask

  task automatic lex_char(input logic [7:0] c);
    logic [7:0] p;
    logic [4:0] k;
    if (c == stt_pkg::CH_LF) begin
      if (cur_line != POS_SAT) cur_line++;
      cur_col = '0;
    end else if (cur_col != POS_SAT) begin
      cur_col++;
    end

    case (lex_mode) inside
      stt_pkg::MODE_IDENT, stt_pkg::MODE_INT: begin
        k = (lex_mode == stt_pkg::MODE_IDENT) ? stt_pkg::KIND_IDENT : stt_pkg::KIND_INT;
        if ((lex_mode == stt_pkg::MODE_IDENT && is_name_char(c)) ||
            (lex_mode == stt_pkg::MODE_INT && is_num(c))) begin
          emit(k, c, 1'b1, 1'b0, 1'b0);
        end else begin
          emit(k, 8'h00, 1'b0, 1'b0, 1'b1);
          begin_token(c);
        end
      end
      stt_pkg::MODE_STR: begin
        if (c == stt_pkg::CH_QUOTE || c == stt_pkg::CH_NUL) begin
          emit(stt_pkg::KIND_STR, 8'h00, 1'b0, !str_open, 1'b1);
          str_open = 1'b0;
          lex_mode = stt_pkg::MODE_IDLE;
          if (c == stt_pkg::CH_NUL) begin_token(c);
        end else if (c == stt_pkg::CH_BSLASH) begin
          lex_mode = stt_pkg::MODE_ESC;
        end else begin
          emit(stt_pkg::KIND_STR, c, 1'b1, !str_open, 1'b0);
          str_open = 1'b1;
        end
      end
      stt_pkg::MODE_ESC: begin
        if (c == stt_pkg::CH_NUL) begin
          emit(stt_pkg::KIND_STR, 8'h00, 1'b0, !str_open, 1'b1);
          str_open = 1'b0;
          begin_token(c);
        end else begin
          emit(stt_pkg::KIND_STR,
               (c == "n") ? stt_pkg::CH_LF : ((c == "t") ? stt_pkg::CH_TAB : c),
               1'b1, !str_open, 1'b0);
          str_open = 1'b1;
          lex_mode = stt_pkg::MODE_STR;
        end
      end
      stt_pkg::MODE_PEND: begin
        p = held_op;
        held_op = 8'h00;
        if (p == "/" && c == "/") begin
          lex_mode = stt_pkg::MODE_LINE_CMT;
        end else if (p == "/" && c == "*") begin
          lex_mode = stt_pkg::MODE_BLK_CMT;
        end else begin
          case ({p, c})
            "==":    k = stt_pkg::KIND_EQ;
            "->":    k = stt_pkg::KIND_ARROW;
            "!=":    k = stt_pkg::KIND_NE;
            "<=":    k = stt_pkg::KIND_LE;
            ">=":    k = stt_pkg::KIND_GE;
            "&&":    k = stt_pkg::KIND_LAND;
            "||":    k = stt_pkg::KIND_LOR;
            default: k = stt_pkg::KIND_NONE;
          endcase
          if (k != stt_pkg::KIND_NONE) begin
            emit(k, p, 1'b1, 1'b1, 1'b0);
            emit(k, c, 1'b1, 1'b0, 1'b1);
            lex_mode = stt_pkg::MODE_IDLE;
          end else begin
            // the held character stands alone, then c starts afresh
            case (p)
              "=":     k = stt_pkg::KIND_ASSIGN;
              "-":     k = stt_pkg::KIND_MINUS;
              "!":     k = stt_pkg::KIND_NOT;
              "<":     k = stt_pkg::KIND_LT;
              ">":     k = stt_pkg::KIND_GT;
              "/":     k = stt_pkg::KIND_DIV;
              default: k = stt_pkg::KIND_UNKNOWN;
            endcase
            emit(k, p, 1'b1, 1'b1, 1'b1);
            begin_token(c);
          end
        end
      end
      stt_pkg::MODE_LINE_CMT: begin
        if (c == stt_pkg::CH_LF) lex_mode = stt_pkg::MODE_IDLE;
        else if (c == stt_pkg::CH_NUL) begin_token(c);
      end
      stt_pkg::MODE_BLK_CMT: begin
        if (c == "*") lex_mode = stt_pkg::MODE_BLK_STAR;
        else if (c == stt_pkg::CH_NUL) begin_token(c);
      end
      stt_pkg::MODE_BLK_STAR: begin
        if (c == "/") lex_mode = stt_pkg::MODE_IDLE;
        else if (c == stt_pkg::CH_NUL) begin_token(c);
        else if (c != "*") lex_mode = stt_pkg::MODE_BLK_CMT;
      end
      default: begin_token(c);
    endcase
  endtask

  // drive one character and predict its token words when it is taken
  task automatic push_char(input logic [7:0] c, input bit typed, input stt_pkg::rec_t want);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    lex_char(c);
    if (typed) token_words_due[token_words_due.size() - 1] = want;
  endtask

  task automatic feed(input logic [7:0] c);
    push_char(c, 1'b0, '0);
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed(s[i]);
  endtask

  task automatic add_row(input string txt, input bit ends, input bit typed,
                         input stt_pkg::rec_t want);
    plan_row_t r;
    r.txt   = txt;
    r.ends  = ends;
    r.typed = typed;
    r.want  = want;
    plan.insert(plan.size(), r);
  endtask

  function automatic logic [7:0] name_char(int unsigned i);
    if (i < 26) return 8'(i) + "a";
    if (i < 52) return 8'(i - 26) + "A";
    if (i < 62) return 8'(i - 52) + "0";
    return stt_pkg::CH_USCORE;
  endfunction

  // one lexically plausible piece of source, sometimes plain noise
  task automatic push_fragment();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      c = 8'($urandom_range(0, 52));
      feed(c == 52 ? stt_pkg::CH_USCORE : name_char(c));
      repeat ($urandom_range(0, 7)) feed(name_char($urandom_range(0, 62)));
    end else if (pick < 32) begin
      repeat ($urandom_range(1, 5)) feed(8'($urandom_range(0, 9)) + "0");
    end else if (pick < 42) begin
      feed(stt_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 3) == 0) begin
          feed(stt_pkg::CH_BSLASH);
          case ($urandom_range(0, 4))
            0:       feed("n");
            1:       feed("t");
            2:       feed(stt_pkg::CH_QUOTE);
            3:       feed(stt_pkg::CH_BSLASH);
            default: feed(8'($urandom_range(1, 255)));
          endcase
        end else begin
          do c = 8'($urandom_range(1, 255));
          while (c == stt_pkg::CH_QUOTE || c == stt_pkg::CH_BSLASH);
          feed(c);
        end
      end
      feed(stt_pkg::CH_QUOTE);
    end else if (pick < 62) begin
      feed_text(op_spellings[$urandom_range(0, 27)]);
    end else if (pick < 77) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0:       feed(stt_pkg::CH_SPACE);
          1:       feed(stt_pkg::CH_LF);
          2:       feed(stt_pkg::CH_TAB);
          default: feed(8'($urandom_range(11, 13)));
        endcase
      end
    end else if (pick < 83) begin
      feed_text("//");
      n = $urandom_range(0, 6);
      repeat (n) begin
        do c = 8'($urandom_range(1, 255)); while (c == stt_pkg::CH_LF);
        feed(c);
      end
      feed(stt_pkg::CH_LF);
    end else if (pick < 90) begin
      feed_text("/*");
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 5))
          0:       feed("*");
          1:       feed("/");
          2:       feed(stt_pkg::CH_SPACE);
          3:       feed(stt_pkg::CH_LF);
          4:       feed("x");
          default: feed(8'($urandom_range(1, 255)));
        endcase
      end
      feed_text("*/");
    end else begin
      feed(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result side: compare each word, then draw a random stall of the output
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_words_due.size() == 0) begin
        $error("token_kind: expected no word, got %0d (value %0d)", token_kind_o,
               value_byte_o);
        mismatches++;
      end else begin
        due_word = token_words_due.pop_front();
        check_field("token_kind", 32'(due_word.kind), 32'(token_kind_o));
        check_field("value_byte", 32'(due_word.value), 32'(value_byte_o));
        check_field("has_byte", 32'(due_word.has), 32'(has_byte_o));
        check_field("token_first", 32'(due_word.first), 32'(token_first_o));
        check_field("token_last", 32'(due_word.last), 32'(token_last_o));
        check_field("start_line", 32'(due_word.line), 32'(start_line_o));
        check_field("start_column", 32'(due_word.column), 32'(start_column_o));
      end
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      rx_hold = rx_calm ? 0 : $urandom_range(0, 18);
      out_stall_i <= (rx_hold != 0);
    end else if (rx_hold > 0) begin
      rx_hold--;
      if (rx_hold == 0) out_stall_i <= 1'b0;
    end
  end

  initial begin
    #(20_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    clear_lexer();
    add_row("", 1'b1, 1'b1, token_word(stt_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1,
                                       PW'(1), PW'(1)));
    add_row("+", 1'b0, 1'b1, token_word(stt_pkg::KIND_PLUS, "+", 1'b1, 1'b1, 1'b1,
                                        PW'(1), PW'(1)));
    add_row("\377", 1'b0, 1'b1, token_word(stt_pkg::KIND_UNKNOWN, 8'hFF, 1'b1, 1'b1, 1'b1,
                                           PW'(1), PW'(2)));
    add_row("\001", 1'b0, 1'b1, token_word(stt_pkg::KIND_UNKNOWN, 8'h01, 1'b1, 1'b1, 1'b1,
                                           PW'(1), PW'(3)));
    add_row("\200", 1'b0, 1'b1, token_word(stt_pkg::KIND_UNKNOWN, 8'h80, 1'b1, 1'b1, 1'b1,
                                           PW'(1), PW'(4)));
    add_row("\n  _id9 = 42;\t\r\013\014", 1'b0, 1'b0, '0);
    add_row("a->b - c != !d", 1'b0, 1'b0, '0);
    add_row("x<=y<z>=w>v", 1'b0, 1'b0, '0);
    add_row("p&&q||r&s|t&", 1'b0, 1'b0, '0);
    add_row("(){}[],:;.*%", 1'b0, 1'b0, '0);
    add_row("\"s\\n\\t\\q\\\\\\\"x\" \"\" ", 1'b0, 1'b0, '0);
    add_row("/ /x //line\n/*a**b*/ /* c *//**/7", 1'b0, 1'b0, '0);
    add_row("//c1\n//c2\n/*x*//*y*/q", 1'b0, 1'b0, '0);
    add_row("~@#$`?'^\177", 1'b0, 1'b0, '0);
    add_row("abc", 1'b1, 1'b0, '0);
    add_row("12", 1'b1, 1'b0, '0);
    add_row("\"open", 1'b1, 1'b0, '0);
    add_row("\"esc\\", 1'b1, 1'b0, '0);
    add_row("=", 1'b1, 1'b0, '0);
    add_row("//tail", 1'b1, 1'b0, '0);
    add_row("/*tail*", 1'b1, 1'b0, '0);
    add_row("/*t", 1'b1, 1'b0, '0);
    add_row("a&", 1'b1, 1'b0, '0);
    add_row("| -", 1'b1, 1'b0, '0);
    add_row("\"\"", 1'b1, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      for (int j = 0; j < plan[i].txt.len(); j++)
        push_char(plan[i].txt[j], plan[i].typed, plan[i].want);
      if (plan[i].ends) push_char(stt_pkg::CH_NUL, plan[i].typed, plan[i].want);
    end

    while (sent < 1500) begin
      // once, let the output side drain completely mid-stream
      if (!paused_once && sent >= 800) begin
        paused_once = 1'b1;
        if (token_words_due.size() != 0) begin
          in_valid_i <= 1'b0;
          while (token_words_due.size() != 0) @(posedge clk_i);
        end
      end
      push_fragment();
      if ($urandom_range(0, 39) == 0) feed(stt_pkg::CH_NUL);
      if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    end
    feed(stt_pkg::CH_NUL);
    in_valid_i <= 1'b0;

    while (token_words_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (token_words_due.size() != 0) begin
      $error("token_kind: %0d words still expected at the end", token_words_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
